// ----- rtl/nmea_sentence_checksum_check_top_assert.svh -----
// ----------------------------------------------------------------------------
// NMEA checksum checker assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_CHECK_TOP_ASSERT_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define NSCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nscc_pkg.sv -----
// ----------------------------------------------------------------------------
// nscc_pkg
// Constants, state type and hex decode for the NMEA checksum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nscc_pkg;

    localparam logic [7:0] CH_START   = 8'h24;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CHK_MARKER = 8'd100;
    localparam logic [7:0] NON_HEX    = 8'd255;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
        logic [7:0]  field_counter;
        logic [15:0] length_counter;
    } state_t;

    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = NON_HEX;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h61 + 8'd10;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h41 + 8'd10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nscc_update.sv -----
// ----------------------------------------------------------------------------
// nscc_update
// Per-character next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module nscc_update (
    input  wire logic [7:0]      rx_char,
    input  wire nscc_pkg::state_t cur,
    output nscc_pkg::state_t      nxt,
    output logic                  ok
);

    nscc_pkg::state_t base;
    logic             printable;

    always_comb
    begin
        base = cur;
        if (rx_char == nscc_pkg::CH_START)
        begin
            base = '0;
        end
        else if (rx_char == nscc_pkg::CH_COMMA)
        begin
            base.field_counter = cur.field_counter + 8'd1;
        end
        else if (rx_char == nscc_pkg::CH_STAR)
        begin
            base.field_counter = nscc_pkg::CHK_MARKER;
        end

        printable = (rx_char >= nscc_pkg::CH_SPACE) && (rx_char <= nscc_pkg::CH_TILDE);

        nxt = base;
        if (printable)
        begin
            if (base.field_counter < nscc_pkg::CHK_MARKER)
            begin
                if (rx_char != nscc_pkg::CH_START && rx_char != nscc_pkg::CH_STAR)
                begin
                    nxt.computed_sum = base.computed_sum ^ rx_char;
                end
            end
            else
            begin
                nxt.received_sum = {base.received_sum[3:0], 4'h0}
                                   + nscc_pkg::nibble_of(rx_char);
            end
            if (base.length_counter != nscc_pkg::LEN_MAX)
            begin
                nxt.length_counter = base.length_counter + 16'd1;
            end
        end

        ok = (rx_char == nscc_pkg::CH_LF) && (nxt.computed_sum == nxt.received_sum);
    end

endmodule

`default_nettype wire

// ----- rtl/nmea_sentence_checksum_check_top.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_check_top
// NMEA 0183 sentence checksum checker, one character per item.
// ----------------------------------------------------------------------------
// Each accepted character gives exactly one result: sentence_ok on an LF whose
// sentence checksum matches, plus the current field index and printable
// length. Throughput is one item per cycle unless res_stall holds the result
// register; the sentence state update is combinational. An accepted item is
// held in the input register, then the result register. rx_stall rises only
// when both the input and result registers are full and res_stall is high.
`default_nettype none

module nmea_sentence_checksum_check_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_char,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             sentence_ok,
    output logic [7:0]       field_index,
    output logic [15:0]      char_count
);

    logic             s1_vld_reg;
    logic [7:0]       s1_char_reg;
    nscc_pkg::state_t st_reg;
    nscc_pkg::state_t st_next;
    logic             ok_next;
    logic             res_vld_reg;
    logic             ok_reg;
    logic [7:0]       fi_reg;
    logic [15:0]      cc_reg;
    logic             adv;

    assign adv      = !(res_vld_reg && res_stall);
    assign rx_stall = s1_vld_reg && !adv;

    nscc_update u_update (
        .rx_char (s1_char_reg),
        .cur     (st_reg),
        .nxt     (st_next),
        .ok      (ok_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            st_reg      <= '0;
        end
        else
        begin
            if (!s1_vld_reg || adv)
            begin
                s1_vld_reg <= rx_valid;
            end
            if (adv)
            begin
                res_vld_reg <= s1_vld_reg;
                if (s1_vld_reg)
                begin
                    st_reg <= st_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!s1_vld_reg || adv) && rx_valid)
        begin
            s1_char_reg <= rx_char;
        end
        if (adv && s1_vld_reg)
        begin
            ok_reg <= ok_next;
            fi_reg <= st_next.field_counter;
            cc_reg <= st_next.length_counter;
        end
    end

    assign res_valid   = res_vld_reg;
    assign sentence_ok = ok_reg;
    assign field_index = fi_reg;
    assign char_count  = cc_reg;

`include "nmea_sentence_checksum_check_top_assert.svh"

    `NSCC_ASSERT_NEXT(a_start_resets,
        adv && s1_vld_reg && s1_char_reg == nscc_pkg::CH_START,
        res_valid && char_count == 16'd1 && field_index == 8'd0 && !sentence_ok,
        "start character did not restart the sentence")

    `NSCC_ASSERT_NEXT(a_len_monotonic,
        adv && s1_vld_reg && s1_char_reg != nscc_pkg::CH_START,
        st_reg.length_counter >= $past(st_reg.length_counter),
        "length counter decreased without a start character")

    `NSCC_ASSERT_NEXT(a_sum_frozen,
        adv && s1_vld_reg && st_reg.field_counter >= nscc_pkg::CHK_MARKER
            && s1_char_reg != nscc_pkg::CH_START && s1_char_reg != nscc_pkg::CH_COMMA,
        $stable(st_reg.computed_sum),
        "computed checksum changed inside the checksum field")

    `NSCC_ASSERT_NOW(a_result_match,
        res_valid && char_count == st_reg.length_counter,
        field_index == st_reg.field_counter,
        "result register disagrees with sentence state")

endmodule

`default_nettype wire
